// ===== hw/rtl/tcg_pkg.sv =====
`timescale 1ns / 1ps

package tcg_pkg;

  // geometry defaults
  localparam int GLYPH_COUNT  = 256;
  localparam int GLYPH_ROWS   = 17;
  localparam int TEXT_COLUMNS = 64;
  localparam int TEXT_ROWS    = 32;

  localparam int GLYPH_W    = 8;
  localparam int CURSOR_W   = 6;
  localparam int ROW_MAX    = 63;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int SCALE_W    = 5;
  localparam int SCROLL_W   = 9;
  localparam int PIXEL_X_W  = 9;
  localparam int PIXEL_Y_W  = 10;

  localparam logic [31:0] TRANSPARENT = 32'h8000_0000;

  // input commands
  localparam logic [1:0] CMD_PUT  = 2'd0;
  localparam logic [1:0] CMD_LOAD = 2'd1;
  localparam logic [1:0] CMD_HOME = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_SCROLL = 2'd0;
  localparam logic [1:0] KIND_ROW    = 2'd1;
  localparam logic [1:0] KIND_SWAP   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FG     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALEX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALEY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DBL    = 3'd4;

  typedef struct packed {
    logic in_ready;
    logic do_scroll;
    logic do_row;
    logic do_swap;
  } ctl_cmd_t;

  typedef struct packed {
    logic put_req;
    logic issue_ok;
    logic row_ge;
    logic more_scroll;
    logic row_last;
    logic swap_req;
  } dp_sts_t;

  function automatic logic [SCALE_W-1:0] clamp_scale(input logic [SCALE_W-1:0] s);
    logic [SCALE_W-1:0] r;
    r = s;
    if (s == '0) r = SCALE_W'(1);
    else if (s > SCALE_W'(16)) r = SCALE_W'(16);
    return r;
  endfunction

  function automatic logic [CURSOR_W-1:0] row_inc(input logic [CURSOR_W-1:0] r);
    logic [CURSOR_W-1:0] n;
    n = r;
    if (r < CURSOR_W'(ROW_MAX)) n = r + CURSOR_W'(1);
    return n;
  endfunction

endpackage

// ===== hw/rtl/tcg_in_if.sv =====
`timescale 1ns / 1ps

interface tcg_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] char_code;
  logic [4:0] row_index;
  logic [7:0] row_data;
  logic       end_of_string;

  modport source (
    output valid, cmd, char_code, row_index, row_data, end_of_string,
    input  ready
  );
  modport sink (
    input  valid, cmd, char_code, row_index, row_data, end_of_string,
    output ready
  );
endinterface

// ===== hw/rtl/tcg_out_if.sv =====
`timescale 1ns / 1ps

interface tcg_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [8:0]  pixel_x;
  logic [9:0]  pixel_y;
  logic [7:0]  row_bits;
  logic [31:0] draw_colour;
  logic [31:0] back_colour;
  logic        paint_background;
  logic [4:0]  x_scale;
  logic [4:0]  y_scale;
  logic [8:0]  scroll_pixels;
  logic        last;

  modport source (
    output valid, kind, pixel_x, pixel_y, row_bits, draw_colour, back_colour,
           paint_background, x_scale, y_scale, scroll_pixels, last,
    input  ready
  );
  modport sink (
    input  valid, kind, pixel_x, pixel_y, row_bits, draw_colour, back_colour,
           paint_background, x_scale, y_scale, scroll_pixels, last,
    output ready
  );
endinterface

// ===== hw/rtl/tcg_ram.sv =====
`timescale 1ns / 1ps

module tcg_ram #(
  parameter int Width = 8,
  parameter int Depth = 4352,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/tcg_ctrl.sv =====
`timescale 1ns / 1ps

module tcg_ctrl import tcg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dp_sts_t  sts_i,
  output ctl_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCROLL = 2'd1;
  localparam logic [1:0] S_GLYPH  = 2'd2;
  localparam logic [1:0] S_SWAP   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.put_req) begin
          state_d = sts_i.row_ge ? S_SCROLL : S_GLYPH;
        end
      end
      S_SCROLL: begin
        cmd_o.do_scroll = sts_i.issue_ok;
        if (sts_i.issue_ok && !sts_i.more_scroll) state_d = S_GLYPH;
      end
      S_GLYPH: begin
        cmd_o.do_row = sts_i.issue_ok;
        if (sts_i.issue_ok && sts_i.row_last) begin
          state_d = sts_i.swap_req ? S_SWAP : S_IDLE;
        end
      end
      S_SWAP: begin
        cmd_o.do_swap = sts_i.issue_ok;
        if (sts_i.issue_ok) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/tcg_datapath.sv =====
`timescale 1ns / 1ps

module tcg_datapath import tcg_pkg::*; #(
  parameter int GlyphCount = GLYPH_COUNT,
  parameter int GlyphRows  = GLYPH_ROWS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  ctl_cmd_t              cmd_i,
  output dp_sts_t               sts_o,
  tcg_in_if.sink                in_i,
  tcg_out_if.source             out_o
);

  localparam int StoreDepth = GlyphCount * GlyphRows;
  localparam int AddrW      = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int RowW       = (GlyphRows > 1) ? $clog2(GlyphRows) : 1;

  // configuration
  logic [31:0]        fg_q, bg_q;
  logic [SCALE_W-1:0] scale_x_q, scale_y_q;
  logic               dbl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q      <= 32'hFFFF_FFFF;
      bg_q      <= '0;
      scale_x_q <= SCALE_W'(1);
      scale_y_q <= SCALE_W'(1);
      dbl_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FG:     fg_q      <= cfg_wdata_i[31:0];
        CFG_BG:     bg_q      <= cfg_wdata_i[31:0];
        CFG_SCALEX: scale_x_q <= cfg_wdata_i[SCALE_W-1:0];
        CFG_SCALEY: scale_y_q <= cfg_wdata_i[SCALE_W-1:0];
        CFG_DBL:    dbl_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic [SCALE_W-1:0] sx, sy;
  assign sx = clamp_scale(scale_x_q);
  assign sy = clamp_scale(scale_y_q);

  // input side
  logic accept, put_acc, load_ok;
  logic [31:0] ld_addr_full, base_full;
  logic [10:0] scroll_full;
  logic [SCROLL_W-1:0] scroll_amt;

  assign in_i.ready = cmd_i.in_ready;
  assign accept     = in_i.valid && in_i.ready;
  assign put_acc    = accept && (in_i.cmd == CMD_PUT);
  assign load_ok    = (in_i.cmd == CMD_LOAD)
                   && ({1'b0, in_i.char_code} < 9'(GlyphCount))
                   && ({1'b0, in_i.row_index} < 6'(GlyphRows));

  assign base_full    = 32'(in_i.char_code) * 32'(GlyphRows);
  assign ld_addr_full = base_full + 32'(in_i.row_index);
  assign scroll_full  = 11'(GlyphRows) * 11'(sy);
  assign scroll_amt   = (scroll_full > 11'd511) ? 9'h1FF : scroll_full[SCROLL_W-1:0];

  // item registers
  logic [AddrW-1:0]    base_q;
  logic                code_ok_q, eos_q;
  logic [SCROLL_W-1:0] scroll_amt_q;

  always_ff @(posedge clk_i) begin
    if (put_acc) begin
      base_q       <= base_full[AddrW-1:0];
      code_ok_q    <= ({1'b0, in_i.char_code} < 9'(GlyphCount));
      eos_q        <= in_i.end_of_string;
      scroll_amt_q <= scroll_amt;
    end
  end

  // cursor and counters
  logic [CURSOR_W-1:0] col_q, col_d, row_q, row_d;
  logic [CURSOR_W-1:0] col_n, row_n;
  logic [RowW-1:0]     rcnt_q;
  logic                scnt_q;
  logic                row_last, col_wrap;

  assign row_last = (rcnt_q == RowW'(GlyphRows - 1));
  assign col_wrap = (col_q == CURSOR_W'(TEXT_COLUMNS - 1));
  assign col_n    = col_wrap ? '0 : col_q + CURSOR_W'(1);
  assign row_n    = col_wrap ? row_inc(row_q) : row_q;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept && (in_i.cmd == CMD_HOME)) begin
      col_d = '0;
      row_d = '0;
    end else if (cmd_i.do_scroll) begin
      row_d = row_q - CURSOR_W'(1);
    end else if (cmd_i.do_row && row_last) begin
      col_d = col_n;
      row_d = row_n;
      // end of string forces a newline on top of the advance
      if (eos_q) begin
        col_d = '0;
        row_d = row_inc(row_n);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      rcnt_q <= '0;
      scnt_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (put_acc) begin
        rcnt_q <= '0;
        scnt_q <= 1'b0;
      end else begin
        if (cmd_i.do_row)    rcnt_q <= rcnt_q + RowW'(1);
        if (cmd_i.do_scroll) scnt_q <= 1'b1;
      end
    end
  end

  // glyph store
  logic                ram_en, ram_we;
  logic [AddrW-1:0]    ram_addr, rd_addr;
  logic [GLYPH_W-1:0]  ram_rdata;

  assign rd_addr  = base_q + AddrW'(rcnt_q);
  assign ram_we   = accept && load_ok;
  assign ram_en   = ram_we || (cmd_i.do_row && code_ok_q);
  assign ram_addr = ram_we ? ld_addr_full[AddrW-1:0] : rd_addr;

  tcg_ram #(
    .Width (GLYPH_W),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (in_i.row_data),
    .rdata_o (ram_rdata)
  );

  // issue stage, lines up with the store read
  logic                 s1_vld_q, s1_last_q, s1_ok_q;
  logic [1:0]           s1_kind_q;
  logic [PIXEL_X_W-1:0] s1_px_q;
  logic [PIXEL_Y_W-1:0] s1_py_q;
  logic [15:0]          py_full;
  logic                 issue, out_free, ld;

  assign py_full  = 16'(row_q) * 16'(GlyphRows) + 16'(rcnt_q);
  assign issue    = cmd_i.do_scroll || cmd_i.do_row || cmd_i.do_swap;
  assign out_free = !out_o.valid || out_o.ready;
  assign ld       = s1_vld_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (issue) begin
      s1_vld_q <= 1'b1;
    end else if (ld) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_kind_q <= cmd_i.do_scroll ? KIND_SCROLL : (cmd_i.do_row ? KIND_ROW : KIND_SWAP);
      s1_px_q   <= {col_q, 3'b000};
      s1_py_q   <= py_full[PIXEL_Y_W-1:0];
      s1_ok_q   <= code_ok_q;
      s1_last_q <= cmd_i.do_swap || (cmd_i.do_row && row_last && !(eos_q && dbl_q));
    end
  end

  // result register
  logic out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ld) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      out_o.kind             <= s1_kind_q;
      out_o.last             <= s1_last_q;
      out_o.pixel_x          <= '0;
      out_o.pixel_y          <= '0;
      out_o.row_bits         <= '0;
      out_o.draw_colour      <= '0;
      out_o.back_colour      <= '0;
      out_o.paint_background <= 1'b0;
      out_o.x_scale          <= '0;
      out_o.y_scale          <= '0;
      out_o.scroll_pixels    <= '0;
      case (s1_kind_q)
        KIND_SCROLL: out_o.scroll_pixels <= scroll_amt_q;
        KIND_ROW: begin
          out_o.pixel_x          <= s1_px_q;
          out_o.pixel_y          <= s1_py_q;
          out_o.row_bits         <= s1_ok_q ? ram_rdata : '0;
          out_o.draw_colour      <= fg_q;
          out_o.back_colour      <= bg_q;
          out_o.paint_background <= (bg_q != TRANSPARENT);
          out_o.x_scale          <= sx;
          out_o.y_scale          <= sy;
        end
        default: ;
      endcase
    end
  end

  assign out_o.valid = out_vld_q;

  // status
  logic [CURSOR_W-1:0] row_dec;
  assign row_dec = row_q - CURSOR_W'(1);

  assign sts_o.put_req     = in_i.valid && (in_i.cmd == CMD_PUT);
  assign sts_o.issue_ok    = !s1_vld_q || ld;
  assign sts_o.row_ge      = (row_q >= CURSOR_W'(TEXT_ROWS));
  assign sts_o.more_scroll = (row_dec >= CURSOR_W'(TEXT_ROWS)) && !scnt_q;
  assign sts_o.row_last    = row_last;
  assign sts_o.swap_req    = eos_q && dbl_q;

endmodule

// ===== hw/rtl/text_console_glyph_renderer_core.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake          payload
// in_i      in   valid/ready        cmd, char_code, row_index, row_data, end_of_string
// out_o     out  valid/ready        kind, pixel_x/y, row_bits, colours, scales, scroll, last
// cfg       in   cfg_we_i only      cfg_idx_i, cfg_wdata_i
//
// a put item yields n results, n = scrolls (0..2) + GlyphRows + swap (0..1):
// one result leaves the issue sequencer per cycle unless the pipeline stalls, through a
// store read stage and the result register. load, cursor reset and unknown items issue none.
// reset clears cursor, configuration registers and pipeline valid flags; the glyph store is not cleared.
// a stalled result holds the two-entry pipeline and the sequencer with it.

module text_console_glyph_renderer_core import tcg_pkg::*; #(
  parameter int GlyphCount = GLYPH_COUNT,
  parameter int GlyphRows  = GLYPH_ROWS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  tcg_in_if.sink                in_i,
  tcg_out_if.source             out_o
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  tcg_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  tcg_datapath #(
    .GlyphCount (GlyphCount),
    .GlyphRows  (GlyphRows)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_i        (in_i),
    .out_o       (out_o)
  );

endmodule

// ===== dv/text_console_glyph_renderer_checker.sv =====
`timescale 1ns / 1ps

module text_console_glyph_renderer_checker import tcg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  tcg_in_if                     in_mon,
  tcg_out_if                    out_mon,
  output int                    pending_o,
  output int                    mismatches_o,
  output int                    checked_o,
  output int                    scrolls_o,
  output int                    swaps_o
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [8:0]  pixel_x;
    logic [9:0]  pixel_y;
    logic [7:0]  row_bits;
    logic [31:0] draw_colour;
    logic [31:0] back_colour;
    logic        paint_background;
    logic [4:0]  x_scale;
    logic [4:0]  y_scale;
    logic [8:0]  scroll_pixels;
    logic        last;
  } draw_op_t;

  // glyph image is never cleared, only rows that were loaded get read
  logic [7:0]          glyph_img [GLYPH_COUNT][GLYPH_ROWS];
  logic [CURSOR_W-1:0] col_q;
  logic [CURSOR_W-1:0] row_q;
  logic [31:0]         fg_q;
  logic [31:0]         bg_q;
  logic [SCALE_W-1:0]  sx_q;
  logic [SCALE_W-1:0]  sy_q;
  logic                dbl_q;
  draw_op_t            draw_ops_q [$];
  int                  mismatches;
  int                  checked;
  int                  scrolls;
  int                  swaps;

  function automatic logic [SCALE_W-1:0] eff_scale(input logic [SCALE_W-1:0] s);
    if (s == '0) return SCALE_W'(1);
    if (s > SCALE_W'(16)) return SCALE_W'(16);
    return s;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $realtime, checked, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    end
  endtask

  task automatic advance_row();
    if (row_q < CURSOR_W'(ROW_MAX)) row_q = row_q + 1'b1;
  endtask

  // scrolls first, then the glyph rows, then cursor moves and the optional swap
  task automatic render_put(input logic [7:0] code, input logic eos);
    draw_op_t    op;
    int unsigned scroll_len;
    int unsigned ncol;
    int          nscroll;
    int          r;
    scroll_len = GLYPH_ROWS * int'(eff_scale(sy_q));
    if (scroll_len > 511) scroll_len = 511;
    nscroll = 0;
    while (row_q >= TEXT_ROWS && nscroll < 2) begin
      op = '0;
      op.kind = KIND_SCROLL;
      op.scroll_pixels = 9'(scroll_len);
      draw_ops_q.push_back(op);
      row_q = row_q - 1'b1;
      nscroll++;
    end
    for (r = 0; r < GLYPH_ROWS; r++) begin
      op = '0;
      op.kind = KIND_ROW;
      op.pixel_x = 9'(int'(col_q) * 8);
      op.pixel_y = 10'(int'(row_q) * GLYPH_ROWS + r);
      op.row_bits = (int'(code) < GLYPH_COUNT) ? glyph_img[code][r] : 8'h00;
      op.draw_colour = fg_q;
      op.back_colour = bg_q;
      op.paint_background = (bg_q != TRANSPARENT);
      op.x_scale = eff_scale(sx_q);
      op.y_scale = eff_scale(sy_q);
      draw_ops_q.push_back(op);
    end
    ncol = int'(col_q) + 1;
    if (ncol >= TEXT_COLUMNS) begin
      col_q = '0;
      advance_row();
    end else begin
      col_q = CURSOR_W'(ncol);
    end
    if (eos) begin
      advance_row();
      col_q = '0;
      if (dbl_q) begin
        op = '0;
        op.kind = KIND_SWAP;
        draw_ops_q.push_back(op);
      end
    end
    op = draw_ops_q.pop_back();
    op.last = 1'b1;
    draw_ops_q.push_back(op);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    draw_op_t got;
    draw_op_t want;
    if (!rst_ni) begin
      col_q = '0;
      row_q = '0;
      fg_q = '1;
      bg_q = '0;
      sx_q = SCALE_W'(1);
      sy_q = SCALE_W'(1);
      dbl_q = 1'b0;
      draw_ops_q.delete();
      mismatches = 0;
      checked = 0;
      scrolls = 0;
      swaps = 0;
      pending_o <= 0;
      mismatches_o <= 0;
      checked_o <= 0;
      scrolls_o <= 0;
      swaps_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FG:     fg_q = cfg_wdata_i;
          CFG_BG:     bg_q = cfg_wdata_i;
          CFG_SCALEX: sx_q = cfg_wdata_i[SCALE_W-1:0];
          CFG_SCALEY: sy_q = cfg_wdata_i[SCALE_W-1:0];
          CFG_DBL:    dbl_q = cfg_wdata_i[0];
          default: ;
        endcase
      end

      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.cmd)
          CMD_PUT: render_put(in_mon.char_code, in_mon.end_of_string);
          CMD_LOAD: begin
            if (int'(in_mon.row_index) < GLYPH_ROWS) begin
              glyph_img[in_mon.char_code][in_mon.row_index] = in_mon.row_data;
            end
          end
          CMD_HOME: begin
            col_q = '0;
            row_q = '0;
          end
          default: ;
        endcase
      end

      if (out_mon.valid && out_mon.ready) begin
        got.kind = out_mon.kind;
        got.pixel_x = out_mon.pixel_x;
        got.pixel_y = out_mon.pixel_y;
        got.row_bits = out_mon.row_bits;
        got.draw_colour = out_mon.draw_colour;
        got.back_colour = out_mon.back_colour;
        got.paint_background = out_mon.paint_background;
        got.x_scale = out_mon.x_scale;
        got.y_scale = out_mon.y_scale;
        got.scroll_pixels = out_mon.scroll_pixels;
        got.last = out_mon.last;
        if (draw_ops_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result of kind %0d", got.kind));
        end else begin
          want = draw_ops_q.pop_front();
          check_field("kind", got.kind, want.kind);
          check_field("pixel_x", got.pixel_x, want.pixel_x);
          check_field("pixel_y", got.pixel_y, want.pixel_y);
          check_field("row_bits", got.row_bits, want.row_bits);
          check_field("draw_colour", got.draw_colour, want.draw_colour);
          check_field("back_colour", got.back_colour, want.back_colour);
          check_field("paint_background", got.paint_background, want.paint_background);
          check_field("x_scale", got.x_scale, want.x_scale);
          check_field("y_scale", got.y_scale, want.y_scale);
          check_field("scroll_pixels", got.scroll_pixels, want.scroll_pixels);
          check_field("last", got.last, want.last);
          if (want.kind == KIND_SCROLL) scrolls++;
          if (want.kind == KIND_SWAP) swaps++;
        end
        checked++;
      end

      pending_o <= draw_ops_q.size();
      mismatches_o <= mismatches;
      checked_o <= checked;
      scrolls_o <= scrolls;
      swaps_o <= swaps;
    end
  end

endmodule

// ===== dv/text_console_glyph_renderer_core_test.sv =====
`timescale 1ns / 1ps

module text_console_glyph_renderer_core_test;
  import tcg_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int STALL_LIMIT   = 2000;
  localparam int LONG_HOLD     = 300;
  localparam int HOLD_AT       = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 24;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  tcg_in_if  in_ch ();
  tcg_out_if out_ch ();

  int pending;
  int mismatches;
  int checked;
  int scrolls;
  int swaps;

  // stimulus bookkeeping: only fully loaded glyphs are ever drawn
  bit [GLYPH_ROWS-1:0] rows_loaded [GLYPH_COUNT];
  bit                  glyph_ready [GLYPH_COUNT];
  logic [7:0]          font_codes [$];
  int                  items_sent;
  int                  settings;
  bit                  steady_in;

  text_console_glyph_renderer_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  text_console_glyph_renderer_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .pending_o    (pending),
    .mismatches_o (mismatches),
    .checked_o    (checked),
    .scrolls_o    (scrolls),
    .swaps_o      (swaps)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // called at a clock edge; returns at the edge where the item is taken
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] code,
                           input logic [4:0] ridx, input logic [7:0] rdata,
                           input logic eos);
    int gap;
    if ($urandom_range(0, 15) == 0) steady_in = !steady_in;
    gap = steady_in ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.char_code <= code;
    in_ch.row_index <= ridx;
    in_ch.row_data <= rdata;
    in_ch.end_of_string <= eos;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic load_row(input logic [7:0] code, input logic [4:0] ridx,
                          input logic [7:0] rdata);
    send_item(CMD_LOAD, code, ridx, rdata, 1'($urandom));
    if (int'(ridx) < GLYPH_ROWS) begin
      rows_loaded[code][ridx] = 1'b1;
      if (&rows_loaded[code] && !glyph_ready[code]) begin
        glyph_ready[code] = 1'b1;
        font_codes.push_back(code);
      end
    end
  endtask

  task automatic load_glyph(input logic [7:0] code);
    int r;
    for (r = 0; r < GLYPH_ROWS; r++) load_row(code, 5'(r), 8'($urandom));
  endtask

  task automatic put_char(input logic eos);
    logic [7:0] code;
    code = font_codes[$urandom_range(0, font_codes.size() - 1)];
    send_item(CMD_PUT, code, 5'($urandom), 8'($urandom), eos);
  endtask

  // drop valid, wait for every expected result, then let the pipe go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [31:0] fg, input logic [31:0] bg,
                               input logic [4:0] sx, input logic [4:0] sy,
                               input logic dbl);
    logic [CFG_IDX_W-1:0] idx [5];
    logic [31:0]          val [5];
    int                   i;
    idx = '{CFG_FG, CFG_BG, CFG_SCALEX, CFG_SCALEY, CFG_DBL};
    val = '{fg, bg, 32'(sx), 32'(sy), 32'(dbl)};
    for (i = 0; i < 5; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[i];
      cfg_wdata_i <= val[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  task automatic random_mix(input int n);
    int done;
    int pick;
    int len;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        len = $urandom_range(1, 6);
        repeat (len) put_char($urandom_range(0, 2) == 0);
        done += len;
      end else if (pick < 68) begin
        load_glyph(8'($urandom));
        done += GLYPH_ROWS;
      end else if (pick < 86) begin
        load_row(8'($urandom), 5'($urandom), 8'($urandom));
        done++;
      end else if (pick < 92) begin
        send_item(CMD_HOME, 8'($urandom), 5'($urandom), 8'($urandom), 1'($urandom));
        done++;
      end else begin
        send_item(CMD_UNUSED, 8'($urandom), 5'($urandom), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  function automatic logic [31:0] pick_background();
    return ($urandom_range(0, 2) == 0) ? TRANSPARENT : $urandom;
  endfunction

  initial begin : stimulus
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_FG;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_PUT;
    in_ch.char_code = '0;
    in_ch.row_index = '0;
    in_ch.row_data = '0;
    in_ch.end_of_string = 1'b0;
    items_sent = 0;
    settings = 0;
    steady_in = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values: opaque black background, unit scales, no swap
    load_glyph(8'hFF);
    load_glyph(8'h41);
    send_item(CMD_UNUSED, 8'hFF, 5'h1F, 8'hFF, 1'b1);
    send_item(CMD_LOAD, 8'h41, 5'd17, 8'hAA, 1'b1);
    send_item(CMD_LOAD, 8'h41, 5'd31, 8'h55, 1'b0);
    send_item(CMD_PUT, 8'h41, 5'd31, 8'hFF, 1'b0);
    send_item(CMD_PUT, 8'hFF, 5'd0, 8'h00, 1'b1);
    send_item(CMD_PUT, 8'h41, 5'd17, 8'h80, 1'b0);
    send_item(CMD_HOME, 8'hFF, 5'h1F, 8'hFF, 1'b1);
    send_item(CMD_PUT, 8'h41, 5'd0, 8'h01, 1'b1);
    settle();

    // transparent background, scales below and above range, swaps on
    apply_setting(32'h0, TRANSPARENT, 5'd0, 5'd31, 1'b1);
    send_item(CMD_PUT, 8'hFF, 5'd0, 8'h00, 1'b1);
    send_item(CMD_PUT, 8'h41, 5'd0, 8'h00, 1'b0);
    send_item(CMD_PUT, 8'hFF, 5'd0, 8'h00, 1'b1);
    settle();

    // walk to the last row, fill it to the last column, then force two scrolls
    apply_setting('1, '1, 5'd16, 5'd16, 1'b1);
    send_item(CMD_HOME, 8'h00, 5'd0, 8'h00, 1'b0);
    repeat (TEXT_ROWS - 1) put_char(1'b1);
    repeat (TEXT_COLUMNS - 1) put_char(1'b0);
    put_char(1'b1);
    put_char(1'b0);
    put_char(1'b1);
    settle();

    apply_setting($urandom, pick_background(), 5'($urandom), 5'($urandom), 1'($urandom));
    random_mix(10);
    settle();

    apply_setting(TRANSPARENT, 32'h7FFF_FFFF, 5'd17, 5'd1, 1'b0);
    random_mix(5);
    settle();

    apply_setting($urandom, pick_background(), 5'($urandom), 5'($urandom), 1'b1);
    random_mix(5);
    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d items under %0d register settings, %0d results checked", items_sent,
             settings + 1, checked);
    $display("%0d scroll requests and %0d buffer swaps among them", scrolls, swaps);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : result_sink
    int stall;
    int taken;
    bit steady;
    out_ch.ready = 1'b0;
    taken = 0;
    steady = 1'b0;
    forever begin
      // one long hold-off lets the block back up into its input
      if (taken == HOLD_AT) begin
        stall = LONG_HOLD;
      end else if (steady) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 5);
      end
      if ($urandom_range(0, 19) == 0) steady = !steady;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      taken++;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("no item moved for %0d cycles", STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

endmodule
